FILE: design/pk15_pkg.sv
// Shared types and constants for the 15-to-16 byte packer.
// No dependencies; imported by pk15_pack and pack_15_byte_chunks_to_16_core.
package pk15_pkg;

  localparam int CHUNK_BYTES = 15;
  localparam int BLOCK_BYTES = 16;
  localparam int CHUNK_W     = 8 * CHUNK_BYTES;
  localparam int BLOCK_W     = 8 * BLOCK_BYTES;
  localparam int STEP_W      = 4;
  localparam int OUT_USER_W  = 2;

  // Command codes carried on the input tuser.
  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  typedef logic [CHUNK_W-1:0] chunk_t;
  typedef logic [BLOCK_W-1:0] block_t;
  typedef logic [STEP_W-1:0]  step_t;

  // Outcome of one item as seen by the output stage.
  typedef struct packed {
    logic   has_out;
    logic   is_flush;
    logic   has_residual;
    block_t block;
  } pk15_res_t;

endpackage

FILE: design/pk15_pack.sv
// Combinational byte packer: joins pending bytes with a new chunk, or pads them on a flush.
// Depends on pk15_pkg for types and command codes.
module pk15_pack (
  input  logic               cmd,
  input  pk15_pkg::chunk_t   chunk,
  input  pk15_pkg::chunk_t   pending,
  input  pk15_pkg::step_t    step,
  output pk15_pkg::pk15_res_t res,
  output pk15_pkg::chunk_t   pending_next,
  output pk15_pkg::step_t    step_next
);
  import pk15_pkg::*;

  logic [4:0]   pend_cnt;
  logic [6:0]   drop_sh;
  chunk_t       keep_mask;
  chunk_t       kept;
  block_t       shifted;

  always_comb begin
    pend_cnt = (step == '0) ? 5'd0 : (5'(BLOCK_BYTES) - {1'b0, step});
    drop_sh  = {step, 3'b000};
    for (int j = 0; j < CHUNK_BYTES; j++) begin
      keep_mask[8*j +: 8] = (5'(j) < pend_cnt) ? 8'hFF : 8'h00;
    end
    kept    = pending & keep_mask;
    // place the new chunk right after the valid pending bytes
    shifted = {8'h00, chunk} << {pend_cnt, 3'b000};

    if (cmd == CMD_FLUSH) begin
      res.has_out      = 1'b1;
      res.is_flush     = 1'b1;
      res.has_residual = (step != '0);
      res.block        = {8'h00, kept};
      pending_next     = pending;
      step_next        = step;
    end else begin
      res.has_out      = (step != '0);
      res.is_flush     = 1'b0;
      res.has_residual = 1'b0;
      res.block        = {8'h00, kept} | shifted;
      // bytes of the chunk that did not fit the block stay pending
      pending_next     = chunk >> drop_sh;
      step_next        = step + 4'd1;
    end
  end

endmodule

FILE: design/pack_15_byte_chunks_to_16_core.sv
// Top level of the 15-to-16 byte gearbox: input register, packer, output register.
// Depends on pk15_pkg and pk15_pack.
//
// Usage:
//   Slave channel (s_*): one transaction per 15-byte chunk or flush request.
//     s_tdata holds the chunk bytes, byte 0 in bits 7:0; s_tuser is the command
//     (append or flush).
//   Master channel (m_*): one transaction per packed 16-byte block or flush
//     result. m_tuser flags a flush result and whether bytes were pending.
//   Chunks run in cycles of sixteen: the first chunk of a cycle is only held,
//   each of the following fifteen completes a block. A flush reports the held
//   bytes padded with zeros and leaves the packing state as it is.
//   Path: an accepted transaction is held in the input register and its result
//   is then loaded into the output register, which drives m_tvalid and m_tdata.
//   Throughput: one transaction per clock while the output is not stalled; the
//   packing state is updated in the same cycle as the item leaves the input register.
//   Reset: clears both register valids and the chunk counter, so the next
//   chunk opens a new cycle. Pending bytes are not cleared.
//   Stall: while m_tready is low the result holds in the output register; a
//   further item that produces a result waits in the input register, and
//   s_tready drops once that register is occupied and cannot advance.
module pack_15_byte_chunks_to_16_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  pk15_pkg::chunk_t       s_tdata,   // [63:0] data_lo, [119:64] data_hi
  input  logic                   s_tuser,   // [0] cmd
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output pk15_pkg::block_t       m_tdata,   // [63:0] block_lo, [127:64] block_hi
  output logic [pk15_pkg::OUT_USER_W-1:0] m_tuser  // [0] is_flush, [1] has_residual
);
  import pk15_pkg::*;

  // Input register
  logic   s1_valid;
  logic   s1_cmd;
  chunk_t s1_chunk;

  // Packing state
  chunk_t pending;
  step_t  step;

  pk15_res_t res;
  chunk_t    pending_next;
  step_t     step_next;
  logic      out_free;
  logic      s1_adv;

  pk15_pack u_pack (
    .cmd          (s1_cmd),
    .chunk        (s1_chunk),
    .pending      (pending),
    .step         (step),
    .res          (res),
    .pending_next (pending_next),
    .step_next    (step_next)
  );

  // Advance the held item when its result has somewhere to go, or it gives none.
  assign out_free = !m_tvalid || m_tready;
  assign s1_adv   = s1_valid && (!res.has_out || out_free);
  assign s_tready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_cmd   <= s_tuser;
      s1_chunk <= s_tdata;
    end
  end

  // Update the packing state as each item leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (s1_adv) begin
      step <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      pending <= pending_next;
    end
  end

  // Output register: hold while stalled, load a fresh result otherwise.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= s1_adv && res.has_out;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_adv && res.has_out) begin
      m_tdata <= res.block;
      m_tuser <= {res.has_residual, res.is_flush};
    end
  end

  // A flush never moves the chunk counter.
  a_flush_keeps_step: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_cmd == CMD_FLUSH) |=> (step == $past(step)))
    else $error("flush changed the chunk counter");

  // The first chunk of a cycle gives no result.
  a_first_chunk_silent: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_cmd == CMD_APPEND && step == '0 && !m_tvalid) |=> !m_tvalid)
    else $error("result produced for the first chunk of a cycle");

  // Packed blocks never claim a residual.
  a_append_no_residual: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> !m_tuser[1])
    else $error("packed block flagged with residual");

  // Nothing is offered in the cycle after reset is released.
  a_reset_idle: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> (!m_tvalid && step == '0))
    else $error("output or counter not idle after reset");

endmodule
